FILE: hdl/fpq_pkg.sv
// Package with the shared types, codes and defaults of the framed packet receive queue.
package fpq_pkg;

    localparam int DEF_MAX_PAYLOAD = 32;
    localparam int DEF_QUEUE_SLOTS = 8;

    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int OUT_LEN_W = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd170;
    localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'd85;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER = 2'd0,
        CFG_FOOTER = 2'd1
    } t_cfg_idx;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_TAKEN   = 3'd0,
        ST_FULL    = 3'd1,
        ST_STORED  = 3'd2,
        ST_TOOLONG = 3'd3,
        ST_BADFOOT = 3'd4,
        ST_NOHDR   = 3'd5,
        ST_BYTE    = 3'd6,
        ST_EMPTY   = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_TYPE = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_FOOT = 3'd4
    } t_phase;

    typedef enum logic {
        POP_IDLE = 1'b0,
        POP_DATA = 1'b1
    } t_pop_state;

endpackage

FILE: hdl/fpq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module fpq_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/framed_packet_receive_queue_top.sv
// Top level of the framed packet receive queue: frame parser, packet ring and pop sequencer.
//
// Each word offered on i_start (when o_busy is low) is either a received byte
// (opcode 0) or a pop request (opcode 1). A received byte is taken in the cycle
// it is offered and yields exactly one result in the cycle after, so bytes may
// be offered back to back. A pop of an empty queue also yields one result. A
// pop of a stored packet yields n results, where n is the payload length (one
// for a zero-length packet). The accepting cycle reads the packet's type and
// length from the slot memory and fetches the first payload byte. After it
// o_busy stays high while the pop sequencer is in its data state, each cycle of
// which passes one payload byte to the result registers while the next one is
// read; no new word is accepted until the last is passed. Results appear on the o_
// result ports for exactly one cycle each, marked by o_strobe; the receiver
// cannot stall them, so it must take every word in the cycle it is shown. The
// final result of each input carries o_last_of_run. Frames have the form
// header, type, length, payload, footer; a length above MAX_PAYLOAD or a wrong
// footer drops the frame and the parser hunts for a header again. When all
// QUEUE_SLOTS slots hold packets, a byte offered while hunting is refused.
// The header and footer values are written through the configuration port,
// which is always ready; write it only while the block is idle. Register 0 is
// the header byte and register 1 the footer byte; other indexes are ignored.
module framed_packet_receive_queue_top
    import fpq_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD,
    parameter int QUEUE_SLOTS = DEF_QUEUE_SLOTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Item channel
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_opcode,
    input  logic [BYTE_W-1:0]    i_byte_value,
    // Result channel
    output logic                 o_strobe,
    output logic [STATUS_W-1:0]  o_status,
    output logic [BYTE_W-1:0]    o_packet_type,
    output logic [OUT_LEN_W-1:0] o_packet_length,
    output logic [BYTE_W-1:0]    o_data_byte,
    output logic                 o_last_of_run,
    // Configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    localparam int LEN_W     = $clog2(MAX_PAYLOAD + 1);
    localparam int SLOT_W    = $clog2(QUEUE_SLOTS);
    localparam int INFO_W    = BYTE_W + LEN_W;
    localparam int PAY_DEPTH = QUEUE_SLOTS * MAX_PAYLOAD;
    localparam int PAY_AW    = $clog2(PAY_DEPTH);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);
    localparam logic [PAY_AW-1:0] SLOT_SPAN = PAY_AW'(MAX_PAYLOAD);
    localparam logic [BYTE_W-1:0] MAX_LEN_B = BYTE_W'(MAX_PAYLOAD);

    // Configuration registers.
    logic [BYTE_W-1:0] r_header;
    logic [BYTE_W-1:0] r_footer;

    // Parser and queue control state.
    t_phase            r_phase,       n_phase;
    logic [LEN_W-1:0]  r_count,       n_count;
    logic [LEN_W-1:0]  r_cur_len,     n_cur_len;
    logic [BYTE_W-1:0] r_cur_type,    n_cur_type;
    logic [SLOT_W-1:0] r_read_slot,   n_read_slot;
    logic [SLOT_W-1:0] r_write_slot,  n_write_slot;
    logic              r_full,        n_full;

    // Pop sequencer.
    t_pop_state        r_pop_state,   n_pop_state;
    logic [LEN_W-1:0]  r_pop_idx,     n_pop_idx;

    // Result registers.
    logic                 r_strobe,   n_strobe;
    t_status              r_status,   n_status;
    logic [BYTE_W-1:0]    r_type,     n_type;
    logic [OUT_LEN_W-1:0] r_len,      n_len;
    logic [BYTE_W-1:0]    r_data,     n_data;
    logic                 r_last,     n_last;

    // Memory ports.
    logic              info_we;
    logic [INFO_W-1:0] info_wdata;
    logic              info_re;
    logic [INFO_W-1:0] info_rdata;
    logic              pay_we;
    logic [PAY_AW-1:0] pay_waddr;
    logic              pay_re;
    logic [PAY_AW-1:0] pay_raddr;
    logic [BYTE_W-1:0] pay_rdata;

    logic              accept;
    logic              queue_empty;
    logic [PAY_AW-1:0] write_base;
    logic [PAY_AW-1:0] read_base;
    logic [LEN_W-1:0]  pop_len;
    logic [BYTE_W-1:0] pop_type;
    logic [LEN_W-1:0]  pop_idx_inc;
    logic              pop_last;
    logic [SLOT_W-1:0] write_slot_inc;
    logic [SLOT_W-1:0] read_slot_inc;

    assign accept      = i_start && !o_busy;
    assign queue_empty = (r_read_slot == r_write_slot) && !r_full;
    assign write_base  = PAY_AW'(r_write_slot) * SLOT_SPAN;
    assign read_base   = PAY_AW'(r_read_slot) * SLOT_SPAN;

    assign write_slot_inc = (r_write_slot == LAST_SLOT) ? '0 : r_write_slot + 1'b1;
    assign read_slot_inc  = (r_read_slot == LAST_SLOT) ? '0 : r_read_slot + 1'b1;

    // The slot word holds the type in its upper byte and the length below it.
    assign pop_len     = info_rdata[LEN_W-1:0];
    assign pop_type    = info_rdata[INFO_W-1:LEN_W];
    assign pop_idx_inc = r_pop_idx + 1'b1;
    assign pop_last    = (pop_len == '0) || (pop_idx_inc == pop_len);

    // Configuration writes. The port is always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_footer <= FOOTER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_HEADER: r_header <= i_cfg_data;
                CFG_FOOTER: r_footer <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Next state of the parser, the queue pointers and the pop sequencer.
    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_cur_len    = r_cur_len;
        n_cur_type   = r_cur_type;
        n_read_slot  = r_read_slot;
        n_write_slot = r_write_slot;
        n_full       = r_full;
        n_pop_state  = r_pop_state;
        n_pop_idx    = r_pop_idx;

        n_strobe = 1'b0;
        n_status = ST_TAKEN;
        n_type   = '0;
        n_len    = '0;
        n_data   = '0;
        n_last   = 1'b1;

        info_we    = 1'b0;
        info_wdata = {r_cur_type, LEN_W'(i_byte_value)};
        info_re    = 1'b0;
        pay_we     = 1'b0;
        pay_waddr  = write_base + PAY_AW'(r_count);
        pay_re     = 1'b0;
        pay_raddr  = read_base;

        unique case (r_pop_state)
            POP_IDLE: begin
                if (accept && (i_opcode == OP_BYTE)) begin
                    n_strobe = 1'b1;
                    unique case (r_phase)
                        PH_TYPE: begin
                            n_cur_type = i_byte_value;
                            n_phase    = PH_LEN;
                        end
                        PH_LEN: begin
                            if (i_byte_value > MAX_LEN_B) begin
                                n_status = ST_TOOLONG;
                                n_phase  = PH_HUNT;
                            end else begin
                                info_we   = 1'b1;
                                n_cur_len = LEN_W'(i_byte_value);
                                n_count   = '0;
                                n_phase   = (i_byte_value == '0) ? PH_FOOT : PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            pay_we  = 1'b1;
                            n_count = r_count + 1'b1;
                            if (n_count >= r_cur_len) begin
                                n_phase = PH_FOOT;
                            end
                        end
                        PH_FOOT: begin
                            n_phase = PH_HUNT;
                            if (i_byte_value != r_footer) begin
                                n_status = ST_BADFOOT;
                            end else if (r_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status     = ST_STORED;
                                n_write_slot = write_slot_inc;
                                n_full       = (write_slot_inc == r_read_slot);
                            end
                        end
                        default: begin
                            n_phase = PH_HUNT;
                            if (r_full) begin
                                n_status = ST_FULL;
                            end else if (i_byte_value != r_header) begin
                                n_status = ST_NOHDR;
                            end else begin
                                n_phase = PH_TYPE;
                            end
                        end
                    endcase
                end else if (accept) begin
                    if (queue_empty) begin
                        n_strobe = 1'b1;
                        n_status = ST_EMPTY;
                    end else begin
                        // Fetch the slot word and the first payload byte.
                        info_re     = 1'b1;
                        pay_re      = 1'b1;
                        n_pop_idx   = '0;
                        n_pop_state = POP_DATA;
                    end
                end
            end
            default: begin
                n_strobe = 1'b1;
                n_status = ST_BYTE;
                n_type   = pop_type;
                n_len    = OUT_LEN_W'(pop_len);
                n_data   = (pop_len == '0) ? '0 : pay_rdata;
                n_last   = pop_last;
                if (pop_last) begin
                    n_pop_state = POP_IDLE;
                    n_read_slot = read_slot_inc;
                    n_full      = 1'b0;
                end else begin
                    pay_re    = 1'b1;
                    pay_raddr = read_base + PAY_AW'(pop_idx_inc);
                    n_pop_idx = pop_idx_inc;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_count      <= '0;
            r_read_slot  <= '0;
            r_write_slot <= '0;
            r_full       <= 1'b0;
            r_pop_state  <= POP_IDLE;
            r_strobe     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_count      <= n_count;
            r_read_slot  <= n_read_slot;
            r_write_slot <= n_write_slot;
            r_full       <= n_full;
            r_pop_state  <= n_pop_state;
            r_strobe     <= n_strobe;
        end
    end

    // Payload and result registers need no reset.
    always_ff @(posedge i_clk) begin
        r_cur_len  <= n_cur_len;
        r_cur_type <= n_cur_type;
        r_pop_idx  <= n_pop_idx;
        r_status   <= n_status;
        r_type     <= n_type;
        r_len      <= n_len;
        r_data     <= n_data;
        r_last     <= n_last;
    end

    // Slot memory: type and length of each stored packet.
    fpq_ram #(
        .WIDTH (INFO_W),
        .DEPTH (QUEUE_SLOTS),
        .ADDR_W(SLOT_W)
    ) u_info_ram (
        .i_clk  (i_clk),
        .i_we   (info_we),
        .i_waddr(r_write_slot),
        .i_wdata(info_wdata),
        .i_re   (info_re),
        .i_raddr(r_read_slot),
        .o_rdata(info_rdata)
    );

    // Payload memory: MAX_PAYLOAD bytes per slot.
    fpq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAY_DEPTH),
        .ADDR_W(PAY_AW)
    ) u_payload_ram (
        .i_clk  (i_clk),
        .i_we   (pay_we),
        .i_waddr(pay_waddr),
        .i_wdata(i_byte_value),
        .i_re   (pay_re),
        .i_raddr(pay_raddr),
        .o_rdata(pay_rdata)
    );

    assign o_busy          = (r_pop_state != POP_IDLE);
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_packet_type   = r_type;
    assign o_packet_length = r_len;
    assign o_data_byte     = r_data;
    assign o_last_of_run   = r_last;

endmodule
